@@ rtl/sqmf_pkg.sv @@
// Shared types and constants for the shortest-queue multi-FIFO block.
// Used by every module of the block but sqmf_ram; depends on nothing.
`default_nettype none

package sqmf_pkg;

  // Field widths fixed by the stream formats
  localparam int ID_W        = 48;
  localparam int SEQ_W       = 32;
  localparam int LANE_OUT_W  = 3;
  localparam int TOTAL_W     = 7;
  localparam int EMPTIES_W   = 4;
  localparam int FIRST_W     = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_LANES_W = 4;

  localparam int IN_DATA_W  = ID_W;
  localparam int OUT_BITS   = LANE_OUT_W + ID_W + SEQ_W + TOTAL_W + EMPTIES_W + FIRST_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Defaults for the top-level parameters
  localparam int DEF_LANES      = 4;
  localparam int DEF_LANE_DEPTH = 16;

  // Configuration register map
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic [0:0] REG_LANES_IN_USE = 1'b0;
  localparam logic [CFG_LANES_W-1:0] LANES_IN_USE_RST = 4'd4;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // No empty lane in use
  localparam logic [FIRST_W-1:0] FIRST_NONE = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch;
    logic scan_step;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/sqmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module sqmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/sqmf_ctrl.sv @@
// Sequencer for the shortest-queue multi-FIFO: handshakes and step commands.
// Depends on sqmf_pkg.
`default_nettype none

module sqmf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_req_remove,
  output      logic                in_tready,
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  output      sqmf_pkg::ctrl_cmd_t cmd,
  input  wire sqmf_pkg::ctrl_sts_t sts
);

  sqmf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_tready  = (state_r == sqmf_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sqmf_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req_remove == sqmf_pkg::REQ_REMOVE) ? sqmf_pkg::ST_SCAN
                                                              : sqmf_pkg::ST_EXEC;
        end
      end
      sqmf_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = sqmf_pkg::ST_EXEC;
        end
      end
      sqmf_pkg::ST_EXEC:   state_nxt = sqmf_pkg::ST_FINISH;
      sqmf_pkg::ST_FINISH: state_nxt = sqmf_pkg::ST_IDLE;
      default:             state_nxt = sqmf_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      sqmf_pkg::ST_IDLE:   cmd.latch     = accept;
      sqmf_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      sqmf_pkg::ST_EXEC:   cmd.exec      = 1'b1;
      sqmf_pkg::ST_FINISH: begin
        cmd.finish    = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqmf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // the output register must be free whenever a result lands
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sqmf_pkg::ST_FINISH) |-> !out_valid_r)
    else $error("result lands on an occupied output register");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sqmf_pkg::ST_FINISH))
    else $error("output valid raised outside the finish step");

  a_exec_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sqmf_pkg::ST_EXEC) |->
      ($past(state_r == sqmf_pkg::ST_IDLE) || $past(state_r == sqmf_pkg::ST_SCAN)))
    else $error("execute step entered from an unexpected state");

endmodule

`default_nettype wire

@@ rtl/sqmf_dp.sv @@
// Datapath for the shortest-queue multi-FIFO: lane counters, pointers,
// head cache, entry RAM and result register. Depends on sqmf_pkg, sqmf_ram.
`default_nettype none

module sqmf_dp #(
  parameter int LANES      = sqmf_pkg::DEF_LANES,
  parameter int LANE_DEPTH = sqmf_pkg::DEF_LANE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire sqmf_pkg::ctrl_cmd_t                  cmd,
  output      sqmf_pkg::ctrl_sts_t                  sts,
  input  wire logic [sqmf_pkg::CFG_LANES_W-1:0]     lanes_in_use,
  input  wire logic                                 in_req_remove,
  input  wire logic [sqmf_pkg::ID_W-1:0]            in_item_id,
  output      logic [sqmf_pkg::STATUS_W-1:0]        out_tuser,
  output      logic [sqmf_pkg::OUT_DATA_W-1:0]      out_tdata
);

  localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SLOT_BITS = $clog2(LANE_DEPTH);
  localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
  localparam int ADDR_W    = LANE_BITS + SLOT_BITS;
  localparam int ENTRY_W   = sqmf_pkg::ID_W + sqmf_pkg::SEQ_W;
  localparam int PAD_W     = sqmf_pkg::OUT_DATA_W - sqmf_pkg::OUT_BITS;
  localparam int SUM_W     = sqmf_pkg::TOTAL_W;  // total reported modulo 2^7

  function automatic logic [SLOT_BITS-1:0] next_slot(input logic [SLOT_BITS-1:0] p);
    next_slot = (p == SLOT_BITS'(LANE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // lane state
  logic [CNT_W-1:0]              cnt_r     [LANES];
  logic [SLOT_BITS-1:0]          head_r    [LANES];
  logic [SLOT_BITS-1:0]          tail_r    [LANES];
  logic [sqmf_pkg::ID_W-1:0]     hd_id_r   [LANES];
  logic [sqmf_pkg::SEQ_W-1:0]    hd_seq_r  [LANES];
  logic [sqmf_pkg::SEQ_W-1:0]    last_seq_r;

  // request and scan state
  logic                          req_rm_r;
  logic [sqmf_pkg::ID_W-1:0]     item_r;
  logic [LANE_BITS-1:0]          scan_idx_r;
  logic                          found_r;
  logic [LANE_BITS-1:0]          best_r;
  logic [sqmf_pkg::SEQ_W-1:0]    best_seq_r;
  logic                          refill_r;

  // result of the step, before the statistics are added
  logic [sqmf_pkg::STATUS_W-1:0]   res_status_r;
  logic [sqmf_pkg::LANE_OUT_W-1:0] res_lane_r;
  logic [sqmf_pkg::ID_W-1:0]       res_id_r;
  logic [sqmf_pkg::SEQ_W-1:0]      res_seq_r;

  logic [sqmf_pkg::STATUS_W-1:0]   out_tuser_r;
  logic [sqmf_pkg::OUT_DATA_W-1:0] out_tdata_r;

  // combinational helpers
  logic [sqmf_pkg::CFG_LANES_W-1:0] n_eff;
  logic [LANES-1:0]                 active;
  logic [LANE_BITS-1:0]             ins_best;
  logic                             all_empty;
  logic                             ins_full;
  logic [sqmf_pkg::SEQ_W-1:0]       new_seq;
  logic [sqmf_pkg::SEQ_W-1:0]       scan_diff;
  logic                             scan_take;
  logic [SLOT_BITS-1:0]             rem_next;
  logic                             ram_we;
  logic [ADDR_W-1:0]                ram_waddr;
  logic [ADDR_W-1:0]                ram_raddr;
  logic [ENTRY_W-1:0]               ram_wdata;
  logic [ENTRY_W-1:0]               ram_rdata;
  logic [SUM_W-1:0]                 total_sum;
  logic [sqmf_pkg::EMPTIES_W-1:0]   empties;
  logic [sqmf_pkg::FIRST_W-1:0]     first_empty;

  // clamp the lane count to 1..LANES
  always_comb begin
    if (lanes_in_use == '0) begin
      n_eff = sqmf_pkg::CFG_LANES_W'(1);
    end else if (lanes_in_use > sqmf_pkg::CFG_LANES_W'(LANES)) begin
      n_eff = sqmf_pkg::CFG_LANES_W'(LANES);
    end else begin
      n_eff = lanes_in_use;
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      active[i] = (sqmf_pkg::CFG_LANES_W'(i) < n_eff);
    end
  end

  // shortest lane, ties to the lowest index
  always_comb begin
    ins_best  = '0;
    all_empty = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      if (active[i]) begin
        if (cnt_r[i] != '0) begin
          all_empty = 1'b0;
        end
        if (cnt_r[i] < cnt_r[ins_best]) begin
          ins_best = LANE_BITS'(i);
        end
      end
    end
  end

  assign ins_full = (cnt_r[ins_best] == CNT_W'(LANE_DEPTH));
  assign new_seq  = (all_empty ? '0 : last_seq_r) + 1'b1;

  // oldest head: one lane per scan step, compared modulo 2^32
  assign scan_diff     = hd_seq_r[scan_idx_r] - best_seq_r;
  assign scan_take     = (cnt_r[scan_idx_r] != '0) &&
                         (!found_r || scan_diff[sqmf_pkg::SEQ_W-1]);
  assign sts.scan_last = (sqmf_pkg::CFG_LANES_W'(scan_idx_r) == n_eff - 1'b1);

  assign rem_next = next_slot(head_r[best_r]);

  // entry RAM: write the tail on insert, fetch the new head on remove
  assign ram_we    = cmd.exec && (req_rm_r == sqmf_pkg::REQ_INSERT) && !ins_full;
  assign ram_waddr = {ins_best, tail_r[ins_best]};
  assign ram_wdata = {new_seq, item_r};
  assign ram_raddr = {best_r, rem_next};

  sqmf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 ** ADDR_W)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // statistics over the counts after the update
  always_comb begin
    total_sum   = '0;
    empties     = '0;
    first_empty = sqmf_pkg::FIRST_NONE;
    for (int i = 0; i < LANES; i++) begin
      total_sum = total_sum + SUM_W'(cnt_r[i]);
    end
    for (int i = LANES - 1; i >= 0; i--) begin
      if (active[i] && cnt_r[i] == '0) begin
        empties     = empties + 1'b1;
        first_empty = sqmf_pkg::FIRST_W'(i);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        cnt_r[i]  <= '0;
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      last_seq_r <= '0;
      req_rm_r   <= sqmf_pkg::REQ_INSERT;
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      best_r     <= '0;
      refill_r   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        req_rm_r   <= in_req_remove;
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        best_r     <= '0;
      end
      if (cmd.scan_step) begin
        if (scan_take) begin
          found_r <= 1'b1;
          best_r  <= scan_idx_r;
        end
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.exec) begin
        refill_r <= 1'b0;
        if (req_rm_r == sqmf_pkg::REQ_INSERT) begin
          if (!ins_full) begin
            tail_r[ins_best] <= next_slot(tail_r[ins_best]);
            cnt_r[ins_best]  <= cnt_r[ins_best] + 1'b1;
            last_seq_r       <= new_seq;
          end
        end else if (found_r) begin
          head_r[best_r] <= rem_next;
          cnt_r[best_r]  <= cnt_r[best_r] - 1'b1;
          refill_r       <= (cnt_r[best_r] > CNT_W'(1));
        end
      end
    end
  end

  // payload: request, head cache, result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item_id;
    end
    if (cmd.scan_step && scan_take) begin
      best_seq_r <= hd_seq_r[scan_idx_r];
    end
    if (cmd.exec) begin
      if (req_rm_r == sqmf_pkg::REQ_INSERT) begin
        res_lane_r <= sqmf_pkg::LANE_OUT_W'(ins_best);
        res_id_r   <= item_r;
        if (ins_full) begin
          res_status_r <= sqmf_pkg::STAT_FULL;
          res_seq_r    <= '0;
        end else begin
          res_status_r <= sqmf_pkg::STAT_DONE;
          res_seq_r    <= new_seq;
          if (cnt_r[ins_best] == '0) begin
            hd_id_r[ins_best]  <= item_r;
            hd_seq_r[ins_best] <= new_seq;
          end
        end
      end else if (!found_r) begin
        res_status_r <= sqmf_pkg::STAT_EMPTY;
        res_lane_r   <= '0;
        res_id_r     <= '0;
        res_seq_r    <= '0;
      end else begin
        res_status_r <= sqmf_pkg::STAT_DONE;
        res_lane_r   <= sqmf_pkg::LANE_OUT_W'(best_r);
        res_id_r     <= hd_id_r[best_r];
        res_seq_r    <= best_seq_r;
      end
    end
    if (cmd.finish) begin
      if (refill_r) begin
        hd_id_r[best_r]  <= ram_rdata[sqmf_pkg::ID_W-1:0];
        hd_seq_r[best_r] <= ram_rdata[ENTRY_W-1:sqmf_pkg::ID_W];
      end
      out_tuser_r <= res_status_r;
      out_tdata_r <= {{PAD_W{1'b0}}, first_empty, empties,
                      total_sum[sqmf_pkg::TOTAL_W-1:0], res_seq_r, res_id_r, res_lane_r};
    end
  end

  assign out_tuser = out_tuser_r;
  assign out_tdata = out_tdata_r;

endmodule

`default_nettype wire

@@ rtl/shortest_queue_multi_fifo.sv @@
// Top level of the shortest-queue multi-FIFO: configuration register and
// wiring of sequencer and datapath. Depends on sqmf_pkg, sqmf_ctrl, sqmf_dp.
//
//  channel   direction  bus       carries
//  in_*      in         stream    request: tuser req_type, tdata item_id
//  out_*     out        stream    result: tuser status, tdata lane..first_empty
//  cfg_*     in/out     APB       lanes_in_use at byte address 0
//
// Insert steps through accept, execute and finish; remove adds a scan of
// N lanes before execute, N being the clamped lanes_in_use: the oldest-head
// search visits one lane per cycle through a single modulo-2^32 comparator.
// rst_n is synchronous, active low; it empties all lanes and restarts the stamp.
// A finished result waits in the output register; the next request is taken
// once that register is free or its transfer completes in the same cycle.
`default_nettype none

module shortest_queue_multi_fifo #(
  parameter int LANES      = sqmf_pkg::DEF_LANES,
  parameter int LANE_DEPTH = sqmf_pkg::DEF_LANE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // request stream
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [sqmf_pkg::IN_DATA_W-1:0]      in_tdata,   // [47:0] item_id
  input  wire logic                                in_tuser,   // [0] req_type
  // result stream
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] lane, [50:3] out_id, [82:51] out_sequence, [89:83] total_count,
  // [93:90] empty_lanes, [97:94] first_empty_lane, [103:98] zero
  output      logic [sqmf_pkg::OUT_DATA_W-1:0]     out_tdata,
  output      logic [sqmf_pkg::STATUS_W-1:0]       out_tuser,  // [1:0] status
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [sqmf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [sqmf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output      logic [sqmf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output      logic                                cfg_pready
);

  logic [sqmf_pkg::CFG_LANES_W-1:0] lanes_in_use_r, lanes_in_use_nxt;
  logic                             cfg_wr;
  logic                             cfg_hit;
  sqmf_pkg::ctrl_cmd_t              cmd;
  sqmf_pkg::ctrl_sts_t              sts;

  // Register index is the word address; only the lane count register exists.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[sqmf_pkg::CFG_ADDR_W-1] == sqmf_pkg::REG_LANES_IN_USE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;

  always_comb begin
    lanes_in_use_nxt = lanes_in_use_r;
    if (cfg_wr) begin
      lanes_in_use_nxt = cfg_pwdata[sqmf_pkg::CFG_LANES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_in_use_r <= sqmf_pkg::LANES_IN_USE_RST;
    end else begin
      lanes_in_use_r <= lanes_in_use_nxt;
    end
  end

  // Read back the register; unmapped words read as zero.
  assign cfg_prdata = cfg_hit ? sqmf_pkg::CFG_DATA_W'(lanes_in_use_r) : '0;

  // Sequencer: owns both handshakes and steps the datapath.
  sqmf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_req_remove (in_tuser),
    .in_tready     (in_tready),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Datapath: lane bookkeeping, entry storage and the result register.
  sqmf_dp #(
    .LANES      (LANES),
    .LANE_DEPTH (LANE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .lanes_in_use  (lanes_in_use_r),
    .in_req_remove (in_tuser),
    .in_item_id    (in_tdata),
    .out_tuser     (out_tuser),
    .out_tdata     (out_tdata)
  );

endmodule

`default_nettype wire

@@ test/sqmf_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the shortest-queue multi-FIFO: watches the request, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on sqmf_pkg only.
module sqmf_checker #(
  parameter int LANES      = sqmf_pkg::DEF_LANES,
  parameter int LANE_DEPTH = sqmf_pkg::DEF_LANE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  input  wire logic                                in_tready,
  input  wire logic [sqmf_pkg::IN_DATA_W-1:0]      in_tdata,   // [47:0] item_id
  input  wire logic                                in_tuser,   // [0] req_type
  input  wire logic                                out_tvalid,
  input  wire logic                                out_tready,
  // [2:0] lane, [50:3] out_id, [82:51] out_sequence, [89:83] total_count,
  // [93:90] empty_lanes, [97:94] first_empty_lane, upper bits zero
  input  wire logic [sqmf_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire logic [sqmf_pkg::STATUS_W-1:0]       out_tuser,  // [1:0] status
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic                                cfg_pready,
  input  wire logic [sqmf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [sqmf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output int                                       mismatches,
  output int                                       outstanding
);
  import sqmf_pkg::*;

  localparam int ID_LO    = LANE_OUT_W;
  localparam int SEQ_LO   = ID_LO + ID_W;
  localparam int TOTAL_LO = SEQ_LO + SEQ_W;
  localparam int EMPTY_LO = TOTAL_LO + TOTAL_W;
  localparam int FIRST_LO = EMPTY_LO + EMPTIES_W;
  localparam logic [CFG_ADDR_W-1:0] LANES_ADDR = {REG_LANES_IN_USE, 2'b00};

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [LANE_OUT_W-1:0] lane;
    logic [ID_W-1:0]       id;
    logic [SEQ_W-1:0]      seq;
    logic [TOTAL_W-1:0]    total;
    logic [EMPTIES_W-1:0]  empties;
    logic [FIRST_W-1:0]    first_empty;
  } lane_result_t;

  logic [ID_W-1:0]        slot_id  [LANES][LANE_DEPTH];
  logic [SEQ_W-1:0]       slot_seq [LANES][LANE_DEPTH];
  int                     head_at  [LANES];
  int                     tail_at  [LANES];
  int                     fill     [LANES];
  logic [SEQ_W-1:0]       stamp;
  logic [CFG_LANES_W-1:0] lanes_sel;
  lane_result_t           pending_q[$];
  lane_result_t           want;

  // Apply one request to the lane bank and return what the block should report.
  function automatic lane_result_t serve_request(input logic kind, input logic [ID_W-1:0] id);
    lane_result_t r;
    int n, best, total, empt;
    logic found, all_empty;
    logic [SEQ_W-1:0] best_seq, s, diff;
    r = '0;
    r.first_empty = FIRST_NONE;
    n = int'(lanes_sel);
    if (n < 1) n = 1;
    if (n > LANES) n = LANES;
    best = 0;
    if (kind == REQ_INSERT) begin
      all_empty = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (fill[i] != 0) all_empty = 1'b0;
        if (fill[i] < fill[best]) best = i;
      end
      r.lane = 3'(best);
      r.id   = id;
      if (fill[best] >= LANE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        if (all_empty) stamp = '0;
        stamp = stamp + 1'b1;
        slot_id[best][tail_at[best]]  = id;
        slot_seq[best][tail_at[best]] = stamp;
        tail_at[best] = (tail_at[best] + 1 >= LANE_DEPTH) ? 0 : tail_at[best] + 1;
        fill[best]++;
        r.status = STAT_DONE;
        r.seq    = stamp;
      end
    end else begin
      found    = 1'b0;
      best_seq = '0;
      for (int i = 0; i < n; i++) begin
        if (fill[i] != 0) begin
          s    = slot_seq[i][head_at[i]];
          diff = s - best_seq;
          // older head wins, modulo-2^32 compare; ties keep the lower lane
          if (!found || diff[SEQ_W-1]) begin
            found    = 1'b1;
            best     = i;
            best_seq = s;
          end
        end
      end
      if (!found) begin
        r.status = STAT_EMPTY;
      end else begin
        r.status = STAT_DONE;
        r.lane   = 3'(best);
        r.id     = slot_id[best][head_at[best]];
        r.seq    = slot_seq[best][head_at[best]];
        head_at[best] = (head_at[best] + 1 >= LANE_DEPTH) ? 0 : head_at[best] + 1;
        fill[best]--;
      end
    end
    total = 0;
    for (int i = 0; i < LANES; i++) total += fill[i];
    empt = 0;
    for (int i = 0; i < n; i++) begin
      if (fill[i] == 0) begin
        if (empt == 0) r.first_empty = 4'(i);
        empt++;
      end
    end
    r.total   = 7'(total);
    r.empties = 4'(empt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        head_at[i] = 0;
        tail_at[i] = 0;
        fill[i]    = 0;
      end
      stamp     = '0;
      lanes_sel = LANES_IN_USE_RST;
      pending_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == LANES_ADDR)
        lanes_sel = cfg_pwdata[CFG_LANES_W-1:0];
      if (in_tvalid && in_tready)
        pending_q.push_back(serve_request(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got status %0h data %0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = pending_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_tuser));
          check_field("lane", 64'(want.lane), 64'(out_tdata[ID_LO-1:0]));
          check_field("out_id", 64'(want.id), 64'(out_tdata[SEQ_LO-1:ID_LO]));
          check_field("out_sequence", 64'(want.seq), 64'(out_tdata[TOTAL_LO-1:SEQ_LO]));
          check_field("total_count", 64'(want.total), 64'(out_tdata[EMPTY_LO-1:TOTAL_LO]));
          check_field("empty_lanes", 64'(want.empties), 64'(out_tdata[FIRST_LO-1:EMPTY_LO]));
          check_field("first_empty_lane", 64'(want.first_empty),
                      64'(out_tdata[FIRST_LO+FIRST_W-1:FIRST_LO]));
        end
      end
    end
    outstanding = pending_q.size();
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the shortest-queue multi-FIFO testbench: clock, reset, request and
// configuration stimulus, result-side back-pressure, watchdog and verdict.
// Depends on sqmf_pkg, shortest_queue_multi_fifo and sqmf_checker.
module tb_top;
  import sqmf_pkg::*;

  localparam int LANES           = DEF_LANES;
  localparam int LANE_DEPTH      = DEF_LANE_DEPTH;
  localparam int HOLD_CYCLES     = 200;   // long receiver hold-off
  localparam int STALL_LIMIT     = 2000;  // cycles without any transfer
  localparam int SETTLE_CYCLES   = 20;    // settle time before the verdict
  localparam int ITEMS_PER_PHASE = 70;
  localparam int PHASES          = 10;

  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata    = '0;    // [47:0] item_id
  logic                   in_tuser    = 1'b0;  // [0] req_type
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // [2:0] lane, [50:3] out_id, [82:51] out_sequence, [89:83] total_count,
  // [93:90] empty_lanes, [97:94] first_empty_lane, upper bits zero
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]    out_tuser;           // [1:0] status
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int   mismatches;
  int   outstanding;
  logic calm        = 1'b0;  // no idling on either side while set
  int   hold_seq    = 0;     // bump to ask the receiver for a hold-off
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   idle_cycles = 0;

  shortest_queue_multi_fifo #(
    .LANES      (LANES),
    .LANE_DEPTH (LANE_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sqmf_checker #(
    .LANES      (LANES),
    .LANE_DEPTH (LANE_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, none while calm, and a long hold-off
  // whenever the stimulus asks for one. The hold-off is counted here.
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, maybe after a short gap, and hold it until the transfer.
  // Returns at the falling edge after the transfer with tvalid still high.
  task automatic offer(input logic kind, input logic [ID_W-1:0] id);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= id;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop tvalid and hold off until every predicted result has come out.
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write lanes_in_use through the setup and access phases; junk in the
  // upper data bits must be ignored.
  task automatic write_lanes(input logic [CFG_LANES_W-1:0] count);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[CFG_LANES_W-1:0] = count;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_LANES_IN_USE, 2'b00};
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [ID_W-1:0] random_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       r = '0;
      1:       r = '1;
      default: ;
    endcase
    return r[ID_W-1:0];
  endfunction

  initial begin
    int   lane_settings[PHASES];
    mix_t mode;
    int   run_left;
    logic kind;

    // Settings visit the clamp at both ends (0 and 15), one lane, the full
    // bank and the in-between values; switching down leaves entries stranded
    // in lanes out of use, switching back up brings them into selection.
    lane_settings = '{1, 15, 0, 4, 2, 8, 3, 1, 4, 5};
    mode     = MODE_MIXED;
    run_left = 0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset setting of four lanes.
    offer(REQ_REMOVE, '0);                 // remove from an empty bank
    offer(REQ_INSERT, '0);                 // lowest id, stamp restarts at 1
    offer(REQ_INSERT, '1);                 // highest id
    offer(REQ_INSERT, 48'h5555_5555_5555);
    offer(REQ_INSERT, 48'hAAAA_AAAA_AAAA);
    offer(REQ_INSERT, 48'h4142_4344_4546); // all lanes tied, lowest lane wins
    offer(REQ_INSERT, 48'h7A79_7877_7675);
    offer(REQ_REMOVE, 48'hFFFF_0000_FFFF); // id ignored on remove
    offer(REQ_REMOVE, '0);
    offer(REQ_REMOVE, '0);
    offer(REQ_INSERT, 48'h0000_0000_0001);
    offer(REQ_REMOVE, '1);
    offer(REQ_REMOVE, '0);
    offer(REQ_REMOVE, '0);
    offer(REQ_REMOVE, '0);                 // bank drained again
    offer(REQ_REMOVE, '0);                 // empty status once more
    offer(REQ_INSERT, 48'h8000_0000_0000); // stamp restarts after draining
    offer(REQ_REMOVE, '0);

    // Random phases: runs that mostly fill (reaching full lanes), mostly
    // drain (reaching the empty case), or mix, with random ids throughout.
    for (int p = 0; p < PHASES; p++) begin
      wait_results();
      write_lanes(lane_settings[p][CFG_LANES_W-1:0]);
      calm = (p == 5);
      if (p == 3) hold_seq++;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 6 && k == ITEMS_PER_PHASE / 2) wait_results();
        if (run_left == 0) begin
          mode     = mix_t'($urandom_range(0, 2));
          run_left = $urandom_range(8, 30);
        end
        run_left--;
        case (mode)
          MODE_FILL:  kind = ($urandom_range(0, 9) < 9) ? REQ_INSERT : REQ_REMOVE;
          MODE_DRAIN: kind = ($urandom_range(0, 9) < 9) ? REQ_REMOVE : REQ_INSERT;
          default:    kind = ($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_REMOVE;
        endcase
        offer(kind, random_id());
      end
    end
    calm = 1'b0;

    // Drain, then give the block time to show any stray result.
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/sqmf_pkg.sv
rtl/sqmf_ram.sv
rtl/sqmf_ctrl.sv
rtl/sqmf_dp.sv
rtl/shortest_queue_multi_fifo.sv
test/sqmf_checker.sv
test/tb_top.sv
